### rtl/mme_pkg.sv
// shared constants and types for the modular exponentiation unit
// no dependencies
package mme_pkg;

    localparam int MOD_BITS      = 31;
    localparam int CELL_COUNT    = MOD_BITS + 2;
    localparam int DEF_WORD_BITS = 32;
    localparam int ADDR_BITS     = 2;

    localparam logic [ADDR_BITS-1:0] REG_ENC_EXP = 2'd0;
    localparam logic [ADDR_BITS-1:0] REG_DEC_EXP = 2'd1;
    localparam logic [ADDR_BITS-1:0] REG_MODULUS = 2'd2;

    typedef struct packed {
        logic carry;
        logic borrow1;
        logic borrow2;
    } mme_link_t;

    typedef enum logic [1:0] {
        SEL_SUM  = 2'b00,
        SEL_SUB1 = 2'b01,
        SEL_SUB2 = 2'b10
    } mme_sel_t;

endpackage

### rtl/rsa_modular_exponentiation_unit.sv
// channel   signals                         direction
// config    we, addr, wdata                 in, written at any edge with we high
// command   start, busy, mode, value, last  in, transfer when start and not busy
// result    done, result, result_last       out, one cycle strobe
// square-and-multiply over WORD_BITS exponent bits, MSB first, after one reduction
// of value; each modular multiply runs in the bit-cell row, and busy stays high
// until the item is done, so a new command waits for the last result
// a modulus below two answers with zero in the cycle after the command is taken
// reset clears registers to exponent 0, modulus 2; results cannot be stalled
// depends on mme_pkg and mme_mulrow
module rsa_modular_exponentiation_unit
    import mme_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [MOD_BITS-1:0]  wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic                 mode,
    input  logic [MOD_BITS-1:0]  value,
    input  logic                 last,
    output logic                 done,
    output logic [MOD_BITS-1:0]  result,
    output logic                 result_last
);

    localparam int EXT_BITS = (WORD_BITS > MOD_BITS) ? WORD_BITS : MOD_BITS;
    localparam int BIT_W    = $clog2(EXT_BITS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PRE  = 4'b0010,
        ST_SQR  = 4'b0100,
        ST_MUL  = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [MOD_BITS-1:0]  enc_reg;
    logic [MOD_BITS-1:0]  dec_reg;
    logic [MOD_BITS-1:0]  mod_reg;
    logic [EXT_BITS-1:0]  exp_reg;
    logic [MOD_BITS-1:0]  base_reg;
    logic                 mode_reg;
    logic                 last_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic [BIT_W-1:0]     bit_next;
    logic                 done_reg;
    logic                 done_next;
    logic [MOD_BITS-1:0]  result_reg;
    logic [MOD_BITS-1:0]  result_next;
    logic                 go;
    logic [MOD_BITS-1:0]  go_a;
    logic [MOD_BITS-1:0]  go_b;
    logic                 mul_done;
    logic [MOD_BITS-1:0]  prod;
    logic                 take;
    logic                 small_mod;
    logic [MOD_BITS-1:0]  final_val;

    assign busy      = (state_reg != ST_IDLE);
    assign take      = start && !busy;
    assign small_mod = (mod_reg < MOD_BITS'(2));
    assign final_val = mode_reg ? MOD_BITS'(prod[7:0]) : prod;

    always_comb
    begin
        state_next  = state_reg;
        bit_next    = bit_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        go          = 1'b0;
        go_a        = prod;
        go_b        = prod;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (small_mod)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                    else
                    begin
                        go         = 1'b1;
                        go_a       = MOD_BITS'(1);
                        go_b       = value;
                        state_next = ST_PRE;
                    end
                end
            end
            ST_PRE:
            begin
                if (mul_done)
                begin
                    go         = 1'b1;
                    go_a       = MOD_BITS'(1);
                    go_b       = MOD_BITS'(1);
                    bit_next   = BIT_W'(WORD_BITS - 1);
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mul_done)
                begin
                    if (exp_reg[bit_reg])
                    begin
                        go         = 1'b1;
                        go_b       = base_reg;
                        state_next = ST_MUL;
                    end
                    else if (bit_reg == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = final_val;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        go       = 1'b1;
                        bit_next = bit_reg - 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    if (bit_reg == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = final_val;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        go         = 1'b1;
                        bit_next   = bit_reg - 1'b1;
                        state_next = ST_SQR;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    mme_mulrow u_mulrow (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .a     (go_a),
        .b     (go_b),
        .n     (mod_reg),
        .done  (mul_done),
        .p     (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            enc_reg   <= '0;
            dec_reg   <= '0;
            mod_reg   <= MOD_BITS'(2);
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (we)
            begin
                case (addr)
                    REG_ENC_EXP: enc_reg <= wdata;
                    REG_DEC_EXP: dec_reg <= wdata;
                    REG_MODULUS: mod_reg <= wdata;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg    <= bit_next;
        result_reg <= result_next;
        if (take)
        begin
            mode_reg <= mode;
            last_reg <= last;
            exp_reg  <= EXT_BITS'(mode ? dec_reg : enc_reg);
        end
        if (state_reg == ST_PRE && mul_done)
        begin
            base_reg <= prod;
        end
        else if (take)
        begin
            base_reg <= '0;
        end
    end

    assign done        = done_reg;
    assign result      = result_reg;
    assign result_last = last_reg;

endmodule

### rtl/mme_cell.sv
// one bit slice of the modular multiply accumulator
// depends on mme_pkg
module mme_cell
    import mme_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      clr,
    input  logic      en,
    input  logic      shift_in,
    input  logic      add_in,
    input  logic      mod1_in,
    input  logic      mod2_in,
    input  mme_sel_t  sel,
    input  mme_link_t link_in,
    output mme_link_t link_out,
    output logic      acc_bit
);

    logic sum;
    logic dif1;
    logic dif2;
    logic acc_reg;
    logic acc_next;

    always_comb
    begin
        sum              = shift_in ^ add_in ^ link_in.carry;
        link_out.carry   = (shift_in & add_in) | (link_in.carry & (shift_in ^ add_in));
        dif1             = sum ^ mod1_in ^ link_in.borrow1;
        link_out.borrow1 = (~sum & (mod1_in | link_in.borrow1)) | (mod1_in & link_in.borrow1);
        dif2             = sum ^ mod2_in ^ link_in.borrow2;
        link_out.borrow2 = (~sum & (mod2_in | link_in.borrow2)) | (mod2_in & link_in.borrow2);
        case (sel)
            SEL_SUB1: acc_next = dif1;
            SEL_SUB2: acc_next = dif2;
            default:  acc_next = sum;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 1'b0;
        end
        else if (clr)
        begin
            acc_reg <= 1'b0;
        end
        else if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_bit = acc_reg;

endmodule

### rtl/mme_mulrow.sv
// interleaved modular multiplier built from a row of bit cells
// depends on mme_pkg and mme_cell
module mme_mulrow
    import mme_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [MOD_BITS-1:0] a,
    input  logic [MOD_BITS-1:0] b,
    input  logic [MOD_BITS-1:0] n,
    output logic                done,
    output logic [MOD_BITS-1:0] p
);

    localparam int CNT_W = $clog2(MOD_BITS);

    logic [MOD_BITS-1:0]   a_reg;
    logic [MOD_BITS-1:0]   b_reg;
    logic [MOD_BITS-1:0]   n_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [CELL_COUNT-1:0] acc;
    logic [CELL_COUNT-1:0] shift_v;
    logic [CELL_COUNT-1:0] add_v;
    logic [CELL_COUNT-1:0] mod1_v;
    logic [CELL_COUNT-1:0] mod2_v;
    mme_link_t             links [CELL_COUNT+1];
    mme_sel_t              sel;

    assign shift_v = {acc[CELL_COUNT-2:0], 1'b0};
    assign add_v   = CELL_COUNT'(a_reg) & {CELL_COUNT{b_reg[MOD_BITS-1]}};
    assign mod1_v  = CELL_COUNT'(n_reg);
    assign mod2_v  = {mod1_v[CELL_COUNT-2:0], 1'b0};
    assign links[0] = '0;

    always_comb
    begin
        if (!links[CELL_COUNT].borrow2)
        begin
            sel = SEL_SUB2;
        end
        else if (!links[CELL_COUNT].borrow1)
        begin
            sel = SEL_SUB1;
        end
        else
        begin
            sel = SEL_SUM;
        end
    end

    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_cell
        mme_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clr      (go),
            .en       (run_reg),
            .shift_in (shift_v[i]),
            .add_in   (add_v[i]),
            .mod1_in  (mod1_v[i]),
            .mod2_in  (mod2_v[i]),
            .sel      (sel),
            .link_in  (links[i]),
            .link_out (links[i+1]),
            .acc_bit  (acc[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(MOD_BITS - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_reg <= a;
            b_reg <= b;
            n_reg <= n;
        end
        else if (run_reg)
        begin
            b_reg <= {b_reg[MOD_BITS-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign p    = acc[MOD_BITS-1:0];

endmodule
